// ----- src/mbap_pkg.sv -----
// Package for the MBAP request deframer: beat types, result kind and
// reject cause codes, frame size limits. Used by every module in src.
package mbap_pkg;

    // Largest PDU (function code plus data) a frame may carry
    localparam int MAX_PDU_BYTES = 253;
    // Largest header length field that still fits, as a 16-bit compare value
    localparam logic [15:0] MAX_LENGTH = 16'(MAX_PDU_BYTES + 1);
    // Bytes before the first PDU data byte (7 header bytes plus function code)
    localparam logic [8:0] DATA_START = 9'd8;
    // Header length field counts unit id and function code ahead of the data
    localparam logic [15:0] LEN_OVERHEAD = 16'd2;

    // Result kinds
    localparam logic [1:0] KIND_HEADER = 2'd0;
    localparam logic [1:0] KIND_DATA   = 2'd1;
    localparam logic [1:0] KIND_REJECT = 2'd2;

    // Reject causes
    localparam logic [1:0] CAUSE_SHORT     = 2'd0;
    localparam logic [1:0] CAUSE_PROTOCOL  = 2'd1;
    localparam logic [1:0] CAUSE_LEN_SMALL = 2'd2;
    localparam logic [1:0] CAUSE_TOO_LONG  = 2'd3;

    // One received byte
    typedef struct packed {
        logic [7:0] rx_byte;
        logic       buffer_end;
    } t_in_beat;

    // Input register contents as seen by the parser
    typedef struct packed {
        logic     valid;
        t_in_beat beat;
    } t_in_stage;

    // One result beat
    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] trans_id;
        logic [7:0]  unit_id;
        logic [7:0]  func_code;
        logic [7:0]  data_byte;
        logic [7:0]  data_index;
        logic [7:0]  data_count;
        logic [1:0]  reject_cause;
        logic        frame_done;
    } t_res_beat;

endpackage

// ----- src/mbap_in_if.sv -----
// Byte channel into the deframer: valid/ready handshake with byte payload.
// Stands alone; no package needed.
interface mbap_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       buffer_end;

    modport source (output valid, output rx_byte, output buffer_end, input ready);
    modport sink   (input valid, input rx_byte, input buffer_end, output ready);
endinterface

// ----- src/mbap_res_if.sv -----
// Result channel out of the deframer: valid/ready handshake with result fields.
// Stands alone; no package needed.
interface mbap_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [15:0] trans_id;
    logic [7:0]  unit_id;
    logic [7:0]  func_code;
    logic [7:0]  data_byte;
    logic [7:0]  data_index;
    logic [7:0]  data_count;
    logic [1:0]  reject_cause;
    logic        frame_done;

    modport source (
        output valid, output kind, output trans_id, output unit_id,
        output func_code, output data_byte, output data_index,
        output data_count, output reject_cause, output frame_done,
        input ready
    );
    modport sink (
        input valid, input kind, input trans_id, input unit_id,
        input func_code, input data_byte, input data_index,
        input data_count, input reject_cause, input frame_done,
        output ready
    );
endinterface

// ----- src/mbap_in_stage.sv -----
// Input register of the deframer: captures one byte beat ahead of the parser.
// Depends on mbap_pkg and mbap_in_if.
module mbap_in_stage (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    mbap_in_if.sink              i_req,
    input  logic                 i_take,
    output mbap_pkg::t_in_stage  o_stage
);

    logic               r_valid;
    mbap_pkg::t_in_beat r_beat;
    logic               w_accept;

    // Open for a new beat when empty or when the held beat moves on
    assign i_req.ready = !r_valid || i_take;
    assign w_accept    = i_req.valid && i_req.ready;

    // Track occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_accept) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    // Capture payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_beat.rx_byte    <= i_req.rx_byte;
            r_beat.buffer_end <= i_req.buffer_end;
        end
    end

    assign o_stage.valid = r_valid;
    assign o_stage.beat  = r_beat;

endmodule

// ----- src/mbap_parser.sv -----
// Frame parser: header capture, checks, data counting and reject decisions
// for one byte per cycle while i_take is high. Depends on mbap_pkg.
module mbap_parser (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  mbap_pkg::t_in_stage  i_stage,
    input  logic                 i_take,
    output logic                 o_res_valid,
    output mbap_pkg::t_res_beat  o_res
);

    localparam logic [1:0] MODE_RECV     = 2'd0;
    localparam logic [1:0] MODE_OVERSIZE = 2'd1;
    localparam logic [1:0] MODE_IGNORE   = 2'd2;

    logic [8:0]  r_pos,   n_pos;
    logic [15:0] r_trans, n_trans;
    logic [7:0]  r_proto, n_proto;
    logic [15:0] r_len,   n_len;
    logic [7:0]  r_unit,  n_unit;
    logic [7:0]  r_func,  n_func;
    logic [1:0]  r_mode,  n_mode;

    logic [7:0]  w_b;
    logic        w_last;
    logic [15:0] w_len_dec;
    logic [15:0] w_count16;
    logic [8:0]  w_idx;
    logic        w_final;
    logic        w_rej;
    logic [1:0]  w_cause;
    logic        w_frame;
    logic [1:0]  w_kind;
    logic        w_done;

    assign w_b       = i_stage.beat.rx_byte;
    assign w_last    = i_stage.beat.buffer_end;
    assign w_len_dec = r_len - 16'd1;
    assign w_count16 = r_len - mbap_pkg::LEN_OVERHEAD;
    assign w_idx     = r_pos - mbap_pkg::DATA_START;
    assign w_final   = ({8'd0, w_idx} + 17'd3) == {1'b0, r_len};

    // Decide the result and next state for the byte in the input register
    always_comb begin
        n_pos   = r_pos;
        n_trans = r_trans;
        n_proto = r_proto;
        n_len   = r_len;
        n_unit  = r_unit;
        n_func  = r_func;
        n_mode  = r_mode;
        w_rej   = 1'b0;
        w_cause = mbap_pkg::CAUSE_SHORT;
        w_frame = 1'b0;
        w_kind  = mbap_pkg::KIND_HEADER;
        w_done  = 1'b0;

        unique case (r_mode)
            MODE_OVERSIZE: begin
                // Count down the rest of an oversize frame
                n_len = w_len_dec;
                if (w_len_dec == 16'd0) begin
                    w_rej   = 1'b1;
                    w_cause = mbap_pkg::CAUSE_TOO_LONG;
                end else if (w_last) begin
                    w_rej = 1'b1;
                end
            end
            MODE_RECV: begin
                if (r_pos < 9'd7) begin
                    // Collect header bytes
                    unique case (r_pos[2:0])
                        3'd0:    n_trans = {w_b, 8'd0};
                        3'd1:    n_trans = {r_trans[15:8], w_b};
                        3'd2:    n_proto = w_b;
                        3'd3:    n_proto = r_proto | w_b;
                        3'd4:    n_len   = {w_b, 8'd0};
                        3'd5:    n_len   = {r_len[15:8], w_b};
                        default: n_unit  = w_b;
                    endcase
                    n_pos = r_pos + 9'd1;
                    w_rej = w_last;
                end else if (r_pos == 9'd7) begin
                    // Function code: run the header checks in order
                    n_func = w_b;
                    n_pos  = mbap_pkg::DATA_START;
                    if (r_proto != 8'd0) begin
                        w_rej   = 1'b1;
                        w_cause = mbap_pkg::CAUSE_PROTOCOL;
                    end else if (r_len < mbap_pkg::LEN_OVERHEAD) begin
                        w_rej   = 1'b1;
                        w_cause = mbap_pkg::CAUSE_LEN_SMALL;
                    end else if (r_len > mbap_pkg::MAX_LENGTH) begin
                        n_len  = w_count16;
                        n_mode = MODE_OVERSIZE;
                        w_rej  = w_last;
                    end else if (r_len == mbap_pkg::LEN_OVERHEAD) begin
                        w_frame = 1'b1;
                        w_done  = 1'b1;
                    end else if (w_last) begin
                        w_rej = 1'b1;
                    end else begin
                        w_frame = 1'b1;
                    end
                end else begin
                    // Data byte
                    n_pos  = r_pos + 9'd1;
                    w_kind = mbap_pkg::KIND_DATA;
                    if (w_final) begin
                        w_frame = 1'b1;
                        w_done  = 1'b1;
                    end else if (w_last) begin
                        w_rej = 1'b1;
                    end else begin
                        w_frame = 1'b1;
                    end
                end
            end
            default: begin
                // Drop bytes until the buffer ends
            end
        endcase

        if (w_rej || w_done) begin
            n_mode = MODE_IGNORE;
        end

        // Start fresh after every buffer end
        if (w_last) begin
            n_pos   = '0;
            n_trans = '0;
            n_proto = '0;
            n_len   = '0;
            n_unit  = '0;
            n_func  = '0;
            n_mode  = MODE_RECV;
        end
    end

    // Build the result beat
    always_comb begin
        o_res_valid = w_rej || w_frame;
        o_res       = '0;
        if (w_rej) begin
            o_res.kind         = mbap_pkg::KIND_REJECT;
            o_res.reject_cause = w_cause;
        end else begin
            o_res.kind       = w_kind;
            o_res.trans_id   = r_trans;
            o_res.unit_id    = r_unit;
            o_res.func_code  = (w_kind == mbap_pkg::KIND_DATA) ? r_func : w_b;
            o_res.data_count = w_count16[7:0];
            o_res.frame_done = w_done;
            if (w_kind == mbap_pkg::KIND_DATA) begin
                o_res.data_byte  = w_b;
                o_res.data_index = w_idx[7:0];
            end
        end
    end

    // Advance parser state on each consumed byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_trans <= '0;
            r_proto <= '0;
            r_len   <= '0;
            r_unit  <= '0;
            r_func  <= '0;
            r_mode  <= MODE_RECV;
        end else if (i_take) begin
            r_pos   <= n_pos;
            r_trans <= n_trans;
            r_proto <= n_proto;
            r_len   <= n_len;
            r_unit  <= n_unit;
            r_func  <= n_func;
            r_mode  <= n_mode;
        end
    end

endmodule

// ----- src/mbap_out_stage.sv -----
// Result register of the deframer: holds one result beat for the sink.
// Depends on mbap_pkg and mbap_res_if.
module mbap_out_stage (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_load,
    input  mbap_pkg::t_res_beat  i_res,
    output logic                 o_free,
    mbap_res_if.source           o_res
);

    logic                r_valid;
    mbap_pkg::t_res_beat r_res;

    // Slot is free when empty or being drained this cycle
    assign o_free = !r_valid || o_res.ready;

    // Track occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_valid <= 1'b0;
        end
    end

    // Capture payload
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_res.valid        = r_valid;
    assign o_res.kind         = r_res.kind;
    assign o_res.trans_id     = r_res.trans_id;
    assign o_res.unit_id      = r_res.unit_id;
    assign o_res.func_code    = r_res.func_code;
    assign o_res.data_byte    = r_res.data_byte;
    assign o_res.data_index   = r_res.data_index;
    assign o_res.data_count   = r_res.data_count;
    assign o_res.reject_cause = r_res.reject_cause;
    assign o_res.frame_done   = r_res.frame_done;

endmodule

// ----- src/mbap_request_deframer_top.sv -----
// Channel   Dir  Beat                         Handshake
// i_req     in   rx_byte, buffer_end          valid/ready
// o_res     out  kind .. frame_done (9 flds)  valid/ready
//
// One byte per cycle unless the sink stalls a result: an input register, the parser logic, a result register.
// A result passes through the input register and then the result register before it shows on o_res.
// Synchronous active-low reset empties both registers and returns the parser
// to the start of a buffer. A stalled sink holds a result in the output
// register while one more byte waits in the input register; bytes that make
// no result keep moving even while the output is stalled.
// Depends on mbap_pkg, mbap_in_if, mbap_res_if and the three stage modules.
module mbap_request_deframer_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mbap_in_if.sink     i_req,
    mbap_res_if.source  o_res
);

    mbap_pkg::t_in_stage w_stage;
    mbap_pkg::t_res_beat w_res;
    logic                w_res_valid;
    logic                w_out_free;
    logic                w_take;

    // Consume the held byte when its result, if any, has somewhere to go
    assign w_take = w_stage.valid && (w_out_free || !w_res_valid);

    mbap_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_take  (w_take),
        .o_stage (w_stage)
    );

    mbap_parser u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_stage     (w_stage),
        .i_take      (w_take),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    mbap_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_take && w_res_valid),
        .i_res   (w_res),
        .o_free  (w_out_free),
        .o_res   (o_res)
    );

    // A reject never completes a frame
    a_reject_not_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.kind == mbap_pkg::KIND_REJECT) |-> !o_res.frame_done)
        else $error("reject result flagged frame_done");

    // Data bytes stay inside the announced count; the last one closes the frame
    a_data_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.kind == mbap_pkg::KIND_DATA) |->
        ((o_res.data_index < o_res.data_count) &&
         (o_res.frame_done == ({1'b0, o_res.data_index} + 9'd1 ==
                               {1'b0, o_res.data_count}))))
        else $error("data index out of step with data count");

    // A header closes the frame only when there is no data
    a_header_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.kind == mbap_pkg::KIND_HEADER && o_res.frame_done) |->
        (o_res.data_count == 8'd0))
        else $error("header done with data pending");

    // A held byte that cannot move blocks the input
    a_in_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_stage.valid && !w_take) |-> !i_req.ready)
        else $error("input accepted over an unconsumed byte");

endmodule
